### design/nfde_pkg.sv
// Shared types and command codes of the nibble framebuffer draw engine.
package nfde_pkg;

  // Signed coordinate wide enough for start, size and band offsets.
  typedef logic signed [9:0] coord_t;

  localparam logic [2:0] KIND_PIXEL = 3'd0;
  localparam logic [2:0] KIND_HLINE = 3'd1;
  localparam logic [2:0] KIND_VLINE = 3'd2;
  localparam logic [2:0] KIND_RECT  = 3'd3;
  localparam logic [2:0] KIND_GLYPH = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  localparam int GLYPH_BITS = 48;

endpackage

### design/nfde_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module nfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/nibble_framebuffer_draw_engine.sv
// Top level of the nibble framebuffer draw engine.
// The engine keeps a DISP_WIDTH x DISP_HEIGHT display of 4-bit pixels, packed
// two to a byte in one RAM, the even pixel in the high nibble.
// Commands arrive on the input channel (in_valid, in_stall); each accepted
// word yields exactly one result word on the output channel (out_valid,
// out_stall) carrying read_data: the store byte for an in-range read, zero otherwise.
// Every drawing command is split into rectangular regions (one for a pixel,
// line or fill, four bands for an outline, one 1x1 or 2x2 block per glyph
// bit) that are scanned row by row. Each pixel on the display is a RAM read
// and a merged write back; a pixel off the display is passed over.
// The RAM has one read and one write port.
// After reset the engine clears all (DISP_WIDTH*DISP_HEIGHT+1)/2 store bytes,
// one byte per cycle, holding in_stall high meanwhile.
// When the receiver stalls, the result stays in the output register and the
// engine still finishes the next command, then waits for the register.
module nibble_framebuffer_draw_engine #(
  parameter int DISP_WIDTH  = 96,
  parameter int DISP_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [6:0]  pos_x,
  input  logic [6:0]  pos_y,
  input  logic [6:0]  span_w,
  input  logic [6:0]  span_h,
  input  logic [5:0]  border,
  input  logic [3:0]  shade,
  input  logic [47:0] glyph_bits,
  input  logic        large_req,
  input  logic [11:0] byte_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data
);

  localparam int STORE_BYTES = (DISP_WIDTH * DISP_HEIGHT + 1) / 2;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PIX_W       = $clog2(DISP_WIDTH * DISP_HEIGHT);
  localparam nfde_pkg::coord_t WIDTH_C  = nfde_pkg::coord_t'(DISP_WIDTH);
  localparam nfde_pkg::coord_t HEIGHT_C = nfde_pkg::coord_t'(DISP_HEIGHT);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_SCAN, S_MERGE, S_READ, S_RWAIT, S_FIN
  } state_t;

  state_t state;

  // Latched command.
  logic [2:0]  c_kind;
  logic [6:0]  c_x, c_y, c_w, c_h;
  logic [5:0]  c_t;
  logic [3:0]  c_shade;
  logic [47:0] c_bits;
  logic        c_large;
  logic [11:0] c_idx;

  // Region sequencing and scan position.
  logic [5:0]       ridx, rlast;
  nfde_pkg::coord_t rx0, ex, ey, cx, cy;
  logic [ADDR_W-1:0] clr_addr, wr_addr;
  logic             wr_low;
  logic [7:0]       res;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Region of the current index.
  nfde_pkg::coord_t rx, ry, rw, rh, sx, sy, sw, sh, st, gcol, grow, ginc;
  logic             gon;

  always_comb begin
    sx   = nfde_pkg::coord_t'({3'b000, c_x});
    sy   = nfde_pkg::coord_t'({3'b000, c_y});
    sw   = nfde_pkg::coord_t'({3'b000, c_w});
    sh   = nfde_pkg::coord_t'({3'b000, c_h});
    st   = nfde_pkg::coord_t'({4'b0000, c_t});
    ginc = c_large ? nfde_pkg::coord_t'(2) : nfde_pkg::coord_t'(1);
    gcol = nfde_pkg::coord_t'({7'd0, ridx[5:3]}) <<< c_large;
    grow = nfde_pkg::coord_t'({7'd0, ridx[2:0]}) <<< c_large;
    gon  = c_bits[6'd47 - ridx] ^ (c_shade == 4'd0);
    rx = sx;
    ry = sy;
    rw = nfde_pkg::coord_t'(1);
    rh = nfde_pkg::coord_t'(1);
    case (c_kind)
      nfde_pkg::KIND_HLINE: rw = sw;
      nfde_pkg::KIND_VLINE: rh = sh;
      nfde_pkg::KIND_RECT: begin
        if (c_t == 6'd0) begin
          rw = sw;
          rh = sh;
        end else begin
          case (ridx[1:0])
            2'd0: begin
              rw = sw;
              rh = st;
            end
            2'd1: begin
              ry = sy + sh - st;
              rw = sw;
              rh = st;
            end
            2'd2: begin
              rw = st;
              rh = sh;
            end
            default: begin
              rx = sx + sw - st;
              rw = st;
              rh = sh;
            end
          endcase
        end
      end
      nfde_pkg::KIND_GLYPH: begin
        rx = sx + gcol;
        ry = sy + grow;
        rw = gon ? ginc : nfde_pkg::coord_t'(0);
        rh = ginc;
      end
      default: ;
    endcase
  end

  // Scan position tests.
  logic on_disp, x_wrap, y_last, do_adv;
  logic [PIX_W-1:0] pidx;

  always_comb begin
    on_disp = (cx >= 0) && (cx < WIDTH_C) && (cy >= 0) && (cy < HEIGHT_C);
    x_wrap  = (cx + nfde_pkg::coord_t'(1)) >= ex;
    y_last  = (cy + nfde_pkg::coord_t'(1)) >= ey;
    do_adv  = ((state == S_SCAN) && !on_disp) || (state == S_MERGE);
    pidx    = PIX_W'(cx[6:0]) + PIX_W'(cy[6:0]) * PIX_W'(DISP_WIDTH);
  end

  // RAM port selection and nibble merge.
  always_comb begin
    ram_raddr = (state == S_READ) ? ADDR_W'(c_idx) : ADDR_W'(pidx >> 1);
    ram_we    = (state == S_CLEAR) || (state == S_MERGE);
    ram_waddr = (state == S_CLEAR) ? clr_addr : wr_addr;
    if (state == S_CLEAR) begin
      ram_wdata = 8'd0;
    end else if (wr_low) begin
      ram_wdata = {ram_rdata[7:4], c_shade};
    end else begin
      ram_wdata = {c_shade, ram_rdata[3:0]};
    end
  end

  nfde_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // Control sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            c_kind  <= kind;
            c_x     <= pos_x;
            c_y     <= pos_y;
            c_w     <= span_w;
            c_h     <= span_h;
            c_t     <= border;
            c_shade <= shade;
            c_bits  <= glyph_bits;
            c_large <= large_req;
            c_idx   <= byte_index;
            res     <= 8'd0;
            ridx    <= '0;
            if (kind == nfde_pkg::KIND_GLYPH) begin
              rlast <= 6'(nfde_pkg::GLYPH_BITS - 1);
            end else if (kind == nfde_pkg::KIND_RECT && border != 6'd0) begin
              rlast <= 6'd3;
            end else begin
              rlast <= 6'd0;
            end
            if (kind == nfde_pkg::KIND_READ) begin
              state <= S_READ;
            end else if (kind <= nfde_pkg::KIND_GLYPH) begin
              state <= S_SETUP;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SETUP: begin
          if (rw == 0 || rh == 0) begin
            if (ridx == rlast) begin
              state <= S_FIN;
            end else begin
              ridx <= ridx + 1'b1;
            end
          end else begin
            rx0   <= rx;
            cx    <= rx;
            cy    <= ry;
            ex    <= rx + rw;
            ey    <= ry + rh;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (on_disp) begin
            wr_addr <= ADDR_W'(pidx >> 1);
            wr_low  <= pidx[0];
            state   <= S_MERGE;
          end
        end
        S_MERGE: ;
        S_READ: state <= S_RWAIT;
        S_RWAIT: begin
          if (32'(c_idx) < STORE_BYTES) begin
            res <= ram_rdata;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_data <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Step to the next pixel, row or region.
      if (do_adv) begin
        if (x_wrap && y_last) begin
          if (ridx == rlast) begin
            state <= S_FIN;
          end else begin
            ridx  <= ridx + 1'b1;
            state <= S_SETUP;
          end
        end else if (x_wrap) begin
          cx    <= rx0;
          cy    <= cy + nfde_pkg::coord_t'(1);
          state <= S_SCAN;
        end else begin
          cx    <= cx + nfde_pkg::coord_t'(1);
          state <= S_SCAN;
        end
      end
    end
  end

endmodule

### design/nfde_checker.sv
// Port-level checker for the draw engine, bound to the top level.
module nfde_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data
);

  // The store clear keeps the input stalled right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // An accepted command keeps the engine busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("engine accepted two words back to back");

  // A stalled result word holds its value.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data))
    else $error("stalled result word changed");

endmodule

bind nibble_framebuffer_draw_engine nfde_checker u_nfde_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .read_data(read_data)
);

### tb/tb_nibble_framebuffer_draw_engine.sv
// Self-checking testbench of the nibble framebuffer draw engine.
module tb_nibble_framebuffer_draw_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 96;
  localparam int DH = 64;
  localparam int STORE_SIZE = (DW * DH + 1) / 2;
  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [6:0]  pos_x;
  logic [6:0]  pos_y;
  logic [6:0]  span_w;
  logic [6:0]  span_h;
  logic [5:0]  border;
  logic [3:0]  shade;
  logic [47:0] glyph_bits;
  logic        large_req;
  logic [11:0] byte_index;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;

  int     error_count;
  longint cycle_count;

  nibble_framebuffer_draw_engine uut (.*);

  // Counts a mismatch and prints it, for the first 50 mismatches only.
  task automatic report(input string msg);
    error_count++;
    if (error_count <= 50) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // Shadow of the display store and queue of expected read bytes.
  class framebuffer_shadow;
    logic [7:0] store [STORE_SIZE];
    logic [7:0] pending_bytes [$];

    function new();
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void plot(int x, int y, logic [3:0] v);
      int p;
      if (x < 0 || y < 0 || x >= DW || y >= DH) return;
      p = x + y * DW;
      if (p[0]) store[p >> 1][3:0] = v;
      else store[p >> 1][7:4] = v;
    endfunction

    function void fill(int x, int y, int w, int h, logic [3:0] v);
      for (int j = 0; j < h; j++)
        for (int i = 0; i < w; i++) plot(x + i, y + j, v);
    endfunction

    // Applies an accepted command and queues the byte it should return.
    function void note_command(logic [2:0] k, int x, int y, int w, int h, int t,
                               logic [3:0] v, logic [47:0] bits, bit big, int idx);
      logic [7:0] data;
      logic [47:0] b;
      int inc;
      data = 8'h00;
      case (k)
        nfde_pkg::KIND_PIXEL: plot(x, y, v);
        nfde_pkg::KIND_HLINE: fill(x, y, w, 1, v);
        nfde_pkg::KIND_VLINE: fill(x, y, 1, h, v);
        nfde_pkg::KIND_RECT: begin
          if (t > 0) begin
            fill(x, y, w, t, v);
            fill(x, y + h - t, w, t, v);
            fill(x, y, t, h, v);
            fill(x + w - t, y, t, h, v);
          end else begin
            fill(x, y, w, h, v);
          end
        end
        nfde_pkg::KIND_GLYPH: begin
          b = (v == 4'd0) ? ~bits : bits;
          inc = big ? 2 : 1;
          for (int n = 0; n < nfde_pkg::GLYPH_BITS; n++)
            if (b[nfde_pkg::GLYPH_BITS - 1 - n])
              fill(x + (n / 8) * inc, y + (n % 8) * inc, inc, inc, v);
        end
        nfde_pkg::KIND_READ: if (idx < STORE_SIZE) data = store[idx];
        default: ;
      endcase
      pending_bytes.push_back(data);
    endfunction

    task check_result(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected result word %02h", got));
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) report($sformatf("read_data %02h, expected %02h", got, want));
    endtask
  endclass

  framebuffer_shadow shadow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Predicts on every accepted command word.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      shadow.note_command(kind, pos_x, pos_y, span_w, span_h, border, shade,
                          glyph_bits, large_req, byte_index);
  end

  // Checks every accepted result word.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) shadow.check_result(read_data);
  end

  // Random receiver stall, with calm stretches.
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(0, 17);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Presents one command word and waits until it is taken.
  task automatic send_command(logic [2:0] k, logic [6:0] x, logic [6:0] y,
                              logic [6:0] w, logic [6:0] h, logic [5:0] t,
                              logic [3:0] v, logic [47:0] bits, bit big,
                              logic [11:0] idx, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k; pos_x <= x; pos_y <= y; span_w <= w; span_h <= h;
    border <= t; shade <= v; glyph_bits <= bits; large_req <= big;
    byte_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  // Sends one random command, mostly small; many of them read scattered bytes.
  task automatic send_random(int gap);
    logic [2:0] k;
    logic [6:0] x, y, w, h;
    logic [5:0] t;
    logic [3:0] v;
    logic [47:0] bits;
    bit big;
    logic [11:0] idx;
    k = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 2) == 0) k = nfde_pkg::KIND_READ;
    w = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 12));
    h = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 12));
    bits = 48'({$urandom, $urandom});
    x = 7'($urandom_range(0, 127)) & (($urandom_range(0, 1) != 0) ? 7'h7F : 7'h5F);
    y = 7'($urandom_range(0, 127)) & (($urandom_range(0, 1) != 0) ? 7'h7F : 7'h3F);
    t = 6'($urandom_range(0, 63)) & (($urandom_range(0, 1) != 0) ? 6'h3F : 6'h03);
    v = 4'($urandom_range(0, 15));
    big = ($urandom_range(0, 1) != 0);
    idx = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(0, STORE_SIZE - 1));
    send_command(k, x, y, w, h, t, v, bits, big, idx, gap);
  endtask

  initial begin
    int wait_cycles;
    shadow = new();
    error_count = 0;
    cycle_count = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = nfde_pkg::KIND_PIXEL; pos_x = '0; pos_y = '0; span_w = '0; span_h = '0;
    border = '0; shade = '0; glyph_bits = '0; large_req = 1'b0; byte_index = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every kind and the clipping corners.
    send_command(nfde_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 4'hF, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_PIXEL, 95, 63, 0, 0, 0, 4'hA, 0, 0, 0, 1);
    send_command(nfde_pkg::KIND_PIXEL, 127, 127, 0, 0, 0, 4'h5, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 12'(STORE_SIZE - 1), 0);
    send_command(nfde_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 12'hFFF, 0);
    send_command(nfde_pkg::KIND_HLINE, 90, 5, 127, 0, 0, 4'h3, 0, 0, 0, 2);
    send_command(nfde_pkg::KIND_HLINE, 10, 6, 0, 0, 0, 4'h7, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_VLINE, 3, 60, 0, 127, 0, 4'h9, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_VLINE, 4, 0, 0, 0, 0, 4'h9, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_RECT, 20, 20, 10, 8, 0, 4'hC, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_RECT, 40, 30, 12, 9, 2, 4'h6, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_RECT, 50, 10, 0, 5, 63, 4'h1, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_RECT, 70, 40, 4, 3, 3, 4'h2, 0, 0, 0, 0);
    send_command(nfde_pkg::KIND_GLYPH, 0, 40, 0, 0, 0, 4'hE, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
    send_command(nfde_pkg::KIND_GLYPH, 88, 58, 0, 0, 0, 4'h8, 48'hA5C3_0F81_7E42, 1, 0, 0);
    send_command(nfde_pkg::KIND_GLYPH, 10, 50, 0, 0, 0, 4'h0, 48'h8001_F00F_1234, 1, 0, 0);
    send_command(3'd6, 1, 1, 5, 5, 1, 4'h4, 0, 0, 0, 0);
    send_command(3'd7, 1, 1, 5, 5, 1, 4'h4, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++)
      send_command(nfde_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 12'(1000 + 48 * i + 10), 0);

    // Random part; once midway the feed waits for all results to drain.
    for (int n = 0; n < 1000; n++) begin
      if (n == 500) begin
        in_valid <= 1'b0;
        while (shadow.pending_bytes.size() != 0) @(posedge clk);
      end
      send_random((n % 200 < 40) ? 0 : draw_gap());
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (shadow.pending_bytes.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (600) @(posedge clk);
    if (error_count == 0 && shadow.pending_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
